### rtl/cdq_pkg.sv
// Shared types and codes for the circular deque core and its storage cells.
`default_nettype none

package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int FILL_W = 4;

    // operation codes
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // command broadcast to every cell of the row
    typedef logic [1:0] t_cell_cmd;
    localparam t_cell_cmd CMD_HOLD       = 2'd0;
    localparam t_cell_cmd CMD_SHIFT_IN   = 2'd1;  // move one place toward the rear
    localparam t_cell_cmd CMD_SHIFT_OUT  = 2'd2;  // move one place toward the front
    localparam t_cell_cmd CMD_WRITE_REAR = 2'd3;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      wr_sel;  // this cell is the first free slot
        logic      tap;     // this cell holds the rear word
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/cdq_cell.sv
// One storage cell of the deque row: a word plus its slot of the rear-return chain.
`default_nettype none

module cdq_cell (
    input  wire logic                        i_clk,
    input  wire cdq_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic [cdq_pkg::WORD_W-1:0]  i_push_word,
    input  wire logic [cdq_pkg::WORD_W-1:0]  i_from_front,
    input  wire logic [cdq_pkg::WORD_W-1:0]  i_from_rear,
    input  wire logic [cdq_pkg::WORD_W-1:0]  i_ret,
    output logic      [cdq_pkg::WORD_W-1:0]  o_data,
    output logic      [cdq_pkg::WORD_W-1:0]  o_ret
);
    import cdq_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] r_ret;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            CMD_HOLD: begin
            end
            CMD_SHIFT_IN: begin
                r_data <= i_from_front;
            end
            CMD_SHIFT_OUT: begin
                r_data <= i_from_rear;
            end
            CMD_WRITE_REAR: begin
                if (i_ctrl.wr_sel) begin
                    r_data <= i_push_word;
                end
            end
            default: begin
            end
        endcase
    end

    // inject the rear word, otherwise pass the neighbor's toward the front
    always_ff @(posedge i_clk) begin
        r_ret <= i_ctrl.tap ? r_data : i_ret;
    end

    assign o_data = r_data;
    assign o_ret  = r_ret;

endmodule

`default_nettype wire

### rtl/circular_deque_core.sv
// Top level of the circular deque: control, fill counter, result register and the cell row.
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// in       | i_in_valid / o_in_stall   | i_operation, i_push_value
// out      | o_out_valid / i_out_stall | o_pop_value, o_status, o_fill_count
//
// Pushes, front pops and every overflow or underflow register the result word at
// the accepting edge. A rear pop first drains: the return chain carries the rear
// word cell by cell to the front, and the result is loaded once it arrives.
// Reset clears the occupancy count and the control state; the cells keep no reset.
// The input stalls while a rear pop drains, and while a result waits under a stall.

module circular_deque_core #(
    parameter int DEPTH = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic        [1:0]                  i_operation,
    input  wire logic signed [cdq_pkg::WORD_W-1:0]  i_push_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed      [cdq_pkg::WORD_W-1:0]  o_pop_value,
    output logic             [1:0]                  o_status,
    output logic             [cdq_pkg::FILL_W-1:0]  o_fill_count
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [0:0] S_IDLE  = 1'b0;
    localparam logic [0:0] S_DRAIN = 1'b1;

    // control state
    logic [0:0]        r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    // result word
    logic [WORD_W-1:0] r_pop_value, n_pop_value;
    logic [1:0]        r_status, n_status;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              n_load;

    logic              in_acc;
    logic              out_free;
    logic              full;
    logic              empty;
    t_cell_cmd         n_cmd;
    logic [CW+FILL_W-1:0] occ_ext;

    logic [WORD_W-1:0] w_data [DEPTH];
    logic [WORD_W-1:0] w_ret  [DEPTH];

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = (r_state == S_DRAIN) | ~out_free;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign full       = (r_occ == CW'(DEPTH));
    assign empty      = (r_occ == '0);

    // fill count is the occupancy held to the width of the result field
    assign occ_ext    = {{FILL_W{1'b0}}, n_occ};

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        n_cmd       = CMD_HOLD;
        n_load      = 1'b0;
        n_pop_value = '0;
        n_status    = ST_DONE;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_operation)
                        OP_PUSH_FRONT: begin
                            n_load      = 1'b1;
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_cmd = CMD_SHIFT_IN;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        OP_PUSH_REAR: begin
                            n_load      = 1'b1;
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_cmd = CMD_WRITE_REAR;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            n_load      = 1'b1;
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_cmd       = CMD_SHIFT_OUT;
                                n_pop_value = w_data[0];
                                n_occ       = r_occ - CW'(1);
                            end
                        end
                        OP_POP_REAR: begin
                            if (empty) begin
                                n_load      = 1'b1;
                                n_out_valid = 1'b1;
                                n_status    = ST_UNDERFLOW;
                            end else begin
                                // wait for the rear word to reach the front cell
                                n_state = S_DRAIN;
                                n_cnt   = CW'(DEPTH);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CW'(1);
                end else if (out_free) begin
                    n_state     = S_IDLE;
                    n_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_pop_value = w_ret[0];
                    n_occ       = r_occ - CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_fill = occ_ext[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result word until the next result replaces it
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_pop_value <= n_pop_value;
            r_status    <= n_status;
            r_fill      <= n_fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pop_value  = r_pop_value;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

    // cell row: cell 0 holds the front word, cell r_occ-1 the rear word
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctrl        ctrl;
        logic [WORD_W-1:0] from_front;
        logic [WORD_W-1:0] from_rear;
        logic [WORD_W-1:0] ret_in;

        assign ctrl.cmd    = n_cmd;
        assign ctrl.wr_sel = (r_occ == CW'(gi));
        assign ctrl.tap    = (r_occ == CW'(gi + 1));

        if (gi == 0) begin : g_head
            assign from_front = i_push_value;
        end else begin : g_body
            assign from_front = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign from_rear = '0;
            assign ret_in    = '0;
        end else begin : g_inner
            assign from_rear = w_data[gi+1];
            assign ret_in    = w_ret[gi+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_push_word  (i_push_value),
            .i_from_front (from_front),
            .i_from_rear  (from_rear),
            .i_ret        (ret_in),
            .o_data       (w_data[gi]),
            .o_ret        (w_ret[gi])
        );
    end

    // never hold more words than there are cells
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("fill count above depth");

    // no word enters while a rear pop drains
    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> o_in_stall)
        else $error("input taken during rear pop");

    // a rear pop on a non-empty deque starts the drain and gives no result yet
    a_rear_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_POP_REAR && !empty)
        |=> (r_state == S_DRAIN && r_out_valid == 1'b0))
        else $error("rear pop did not drain");

    // a push to a full deque reports overflow and leaves the fill count alone
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_PUSH_FRONT || i_operation == OP_PUSH_REAR) && full)
        |=> (o_out_valid && o_status == ST_OVERFLOW && $stable(r_occ)))
        else $error("overflow not reported");

endmodule

`default_nettype wire

### test/circular_deque_core_test.sv
// Self-checking testbench for circular_deque_core: random and directed deque operations.
`timescale 1ns / 100ps

module circular_deque_core_test;

    import cdq_pkg::*;

    localparam int DEPTH = 8;

    // Traffic shape of the random part: lean toward pushes, toward pops, or even.
    localparam int MOOD_GROW   = 0;
    localparam int MOOD_SHRINK = 1;
    localparam int MOOD_MIXED  = 2;

    // Words at the tail of the run that go without any idling on either side.
    localparam int CALM_TAIL = 100;

    typedef struct {
        logic        [1:0]        op;
        logic signed [WORD_W-1:0] value;
        bit                       pause;  // wait for every result before the next word
    } op_word_t;

    typedef struct {
        logic signed [WORD_W-1:0] pop_value;
        logic        [1:0]        status;
        logic        [FILL_W-1:0] fill;
    } result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic        [1:0]          i_operation = OP_PUSH_FRONT;
    logic signed [WORD_W-1:0]   i_push_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [WORD_W-1:0]   o_pop_value;
    logic        [1:0]          o_status;
    logic        [FILL_W-1:0]   o_fill_count;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Words still to be offered, and results owed by the block in order.
    op_word_t deque_ops[$];
    result_t  pending_results[$];

    int total_ops = 0;
    int ops_sent  = 0;   // advanced by nonblocking assignment so other blocks see a stable count
    int fail_count = 0;

    logic calm;
    assign calm = (ops_sent + CALM_TAIL >= total_ops);

    // ------------------------------------------------------------------
    // Predictor: a plain ring buffer with its own head and fill.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] deque_slots [DEPTH];
    int deque_head = 0;
    int deque_fill = 0;

    function automatic result_t apply_deque_op(logic [1:0] op, logic signed [WORD_W-1:0] value);
        result_t r;
        int      slot;
        r.pop_value = '0;
        r.status    = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (deque_fill >= DEPTH) begin
                // full push: report and leave everything as it was
                r.status = ST_OVERFLOW;
            end else begin
                if (op == OP_PUSH_FRONT) begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    slot = deque_head;
                end else begin
                    slot = (deque_head + deque_fill) % DEPTH;
                end
                deque_slots[slot] = value;
                deque_fill++;
            end
        end else begin
            if (deque_fill == 0) begin
                // empty pop: report and leave everything as it was
                r.status = ST_UNDERFLOW;
            end else begin
                if (op == OP_POP_FRONT) begin
                    r.pop_value = deque_slots[deque_head];
                    deque_head = (deque_head + 1) % DEPTH;
                end else begin
                    r.pop_value = deque_slots[(deque_head + deque_fill - 1) % DEPTH];
                end
                // head stays where it is once the queue runs empty
                deque_fill--;
            end
        end
        r.fill = deque_fill[FILL_W-1:0];
        return r;
    endfunction

    task automatic queue_op(logic [1:0] op, logic signed [WORD_W-1:0] value);
        deque_ops.push_back('{op: op, value: value, pause: 1'b0});
        total_ops++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words from deque_ops, with random gaps between them.
    // ------------------------------------------------------------------
    int send_gap   = 0;   // idle cycles left before the next word
    int send_quiet = 0;   // accepted words left to go without gaps

    always @(posedge i_clk) begin : drive_ops
        op_word_t nxt;
        bit       offer;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_operation  <= OP_PUSH_FRONT;
            i_push_value <= '0;
        end else begin
            // Predict at the accepting edge, from the word that was on the port.
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(apply_deque_op(i_operation, i_push_value));
                ops_sent <= ops_sent + 1;
                if (send_quiet > 0) begin
                    send_quiet--;
                end else if (!calm) begin
                    case ($urandom_range(19))
                        0:       send_quiet = $urandom_range(20, 60);
                        1, 2, 3, 4: send_gap = $urandom_range(1, 12);
                        default: ;
                    endcase
                end
            end
            // Hold a stalled word; otherwise pick what goes out next.
            if (!(i_in_valid && o_in_stall)) begin
                offer = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (deque_ops.size() > 0) begin
                    if (deque_ops[0].pause) begin
                        // drop the marker only once the block owes nothing
                        if (pending_results.size() == 0)
                            void'(deque_ops.pop_front());
                    end else begin
                        nxt   = deque_ops.pop_front();
                        offer = 1'b1;
                    end
                end
                i_in_valid <= offer;
                if (offer) begin
                    i_operation  <= nxt.op;
                    i_push_value <= nxt.value;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, quiet stretches, and long hold-offs
    // that back the block up into its input.
    // ------------------------------------------------------------------
    int rx_cycles = 0;
    int hold_off  = 0;
    int stall_left = 0;
    int rx_quiet  = 0;

    always @(posedge i_clk) begin : stall_results
        bit next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == 600 || (rx_cycles == 4000 && !calm))
                hold_off = 120;
            next_stall = 1'b0;
            if (hold_off > 0) begin
                hold_off--;
                next_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end else if (rx_quiet > 0) begin
                rx_quiet--;
            end else if (!calm) begin
                case ($urandom_range(29))
                    0: rx_quiet = $urandom_range(30, 90);
                    1, 2, 3, 4, 5, 6: begin
                        stall_left = $urandom_range(0, 11);
                        next_stall = 1'b1;
                    end
                    default: ;
                endcase
            end
            i_out_stall <= next_stall;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: pop_value 0x%0h status %0d fill %0d",
                       o_pop_value, o_status, o_fill_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pop_value", want.pop_value, o_pop_value);
                check_field("status", WORD_W'(want.status), WORD_W'(o_status));
                check_field("fill_count", WORD_W'(want.fill), WORD_W'(o_fill_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int mood;
        int run_left;
        int push_pct;
        logic [1:0] op;
        logic signed [WORD_W-1:0] value;

        // Both empty pops, then single words at the extremes through each end.
        queue_op(OP_POP_FRONT, 32'sh1234_5678);
        queue_op(OP_POP_REAR, -32'sd1);
        queue_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);   // head wraps below slot zero
        queue_op(OP_PUSH_REAR, 32'sh8000_0000);
        queue_op(OP_POP_REAR, '0);
        queue_op(OP_POP_FRONT, '0);                // emptied, head advances one slot
        // Fill from both ends until full, then push into the full queue.
        queue_op(OP_PUSH_REAR, -32'sd1);
        queue_op(OP_PUSH_REAR, 32'sd0);
        queue_op(OP_PUSH_FRONT, 32'sd1);
        queue_op(OP_PUSH_FRONT, 32'sh5555_5555);
        queue_op(OP_PUSH_REAR, 32'shAAAA_AAAA);
        queue_op(OP_PUSH_FRONT, 32'sh8000_0000);
        queue_op(OP_PUSH_REAR, 32'sh7FFF_FFFF);
        queue_op(OP_PUSH_FRONT, 32'sd4);
        queue_op(OP_PUSH_FRONT, 32'sd99);
        queue_op(OP_PUSH_REAR, 32'sd98);
        // Drain from both ends in mixed order, then pop once more from empty.
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_REAR, '0);
        queue_op(OP_POP_REAR, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_REAR, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_REAR, '0);
        queue_op(OP_POP_FRONT, '0);
        deque_ops.push_back('{op: OP_PUSH_FRONT, value: '0, pause: 1'b1});

        // Random part: runs that grow, shrink or churn the queue, so it hits
        // full and empty often with random words in between.
        run_left = 0;
        mood     = MOOD_MIXED;
        for (int n = 0; n < 740; n++) begin
            if (run_left == 0) begin
                mood     = $urandom_range(2);
                run_left = $urandom_range(10, 40);
            end
            run_left--;
            case (mood)
                MOOD_GROW:   push_pct = 80;
                MOOD_SHRINK: push_pct = 25;
                default:     push_pct = 50;
            endcase
            if (n == 370)
                deque_ops.push_back('{op: OP_PUSH_FRONT, value: '0, pause: 1'b1});
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
            case ($urandom_range(11))
                0:       value = 32'sh8000_0000;
                1:       value = 32'sh7FFF_FFFF;
                2:       value = -32'sd1;
                3:       value = '0;
                default: value = $urandom;
            endcase
            queue_op(op, value);
        end

        // Hold reset at the start, then release it.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every result to come out,
        // then leave room for a stray late result.
        while (ops_sent < total_ops || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
